>>> hdl/fct_pkg.sv
// Package for the Fortran chunk tokenizer: word types, chunk kind codes
// and character class functions. No dependencies.
`default_nettype none

package fct_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 3;

    // Chunk kind codes; MODE_NONE marks that no chunk is open
    localparam logic [KIND_W-1:0] KIND_WORD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SKIP   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STRING = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OTHER  = 3'd4;
    localparam logic [KIND_W-1:0] MODE_NONE   = 3'd7;

    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
    localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_LC_C   = 8'h63;
    localparam logic [CHAR_W-1:0] CH_UC_C   = 8'h43;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last_in_text;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic [KIND_W-1:0] chunk_kind;
        logic              chunk_start;
    } out_word_t;

    function automatic logic is_space_ch(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit_ch(input logic [CHAR_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha_ch(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_word_ch(input logic [CHAR_W-1:0] c);
        return is_alpha_ch(c) || is_digit_ch(c) || (c == CH_USCORE);
    endfunction

    // Digits, '.', hex letters, X/x and L/l
    function automatic logic is_number_ch(input logic [CHAR_W-1:0] c);
        return is_digit_ch(c) || (c == 8'h2E) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46) || (c == 8'h58) || (c == 8'h78)
            || (c == 8'h4C) || (c == 8'h6C);
    endfunction

    function automatic logic opens_comment(input logic [CHAR_W-1:0] c,
                                           input logic col1,
                                           input logic fixed);
        return (c == CH_HASH) || (c == CH_BANG)
            || (((c == CH_LC_C) || (c == CH_UC_C) || (c == CH_STAR)) && col1 && fixed);
    endfunction

endpackage

`default_nettype wire

>>> hdl/fortran_chunk_tokenizer.sv
// Fortran chunk tokenizer top level: input register, classifier logic and
// result register. Depends on fct_pkg.
`default_nettype none
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one source character per
//   word with a flag on the last character of a text. Output channel
//   out_valid/out_ready/out_data returns each character with its chunk kind
//   and a chunk-start flag, one result word per input word, in order.
//   cfg_wr_en/cfg_wr_data set the fixed-form bit; write it only while idle.
// Path: a word passes the input register, then the result register.
//   Throughput: one word per cycle while out_ready is high; the chunk state
//   updates in the cycle that moves a word into the result register.
// Reset: both stages empty, chunk state cleared, column one set, fixed-form
//   mode off. The chunk state also clears after a word flagged last_in_text.
// Stall: when out_ready is low the result holds, the input register fills,
//   and in_ready drops until the result is taken.
//
module fortran_chunk_tokenizer
    import fct_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_data,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data
);

    logic        fixed_form_reg;
    logic        s1_valid_reg;
    in_word_t    s1_data_reg;
    logic        out_valid_reg;
    out_word_t   out_data_reg;

    logic [KIND_W-1:0] mode_reg, mode_next;
    logic        in_comment_reg, in_comment_next;
    logic        quote_dbl_reg, quote_dbl_next;
    logic        str_closed_reg, str_closed_next;
    logic        col_one_reg, col_one_next;

    logic        advance;
    out_word_t   result;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        logic [CHAR_W-1:0] c;
        logic [KIND_W-1:0] kind;
        logic              handled;
        logic              start;
        logic              col1;

        c               = s1_data_reg.char_in;
        col1            = col_one_reg;
        kind            = KIND_OTHER;
        handled         = 1'b0;
        start           = 1'b0;
        mode_next       = mode_reg;
        in_comment_next = in_comment_reg;
        quote_dbl_next  = quote_dbl_reg;
        str_closed_next = str_closed_reg;

        case (mode_reg)
            KIND_WORD:
            begin
                if (is_word_ch(c))
                begin
                    kind    = KIND_WORD;
                    handled = 1'b1;
                end
            end
            KIND_SKIP:
            begin
                if (in_comment_reg)
                begin
                    if (c == CH_NL)
                        in_comment_next = 1'b0;
                    handled = 1'b1;
                end
                else if (is_space_ch(c))
                    handled = 1'b1;
                else if (opens_comment(c, col1, fixed_form_reg))
                begin
                    in_comment_next = 1'b1;
                    handled         = 1'b1;
                end
                if (handled)
                    kind = KIND_SKIP;
            end
            KIND_NUMBER:
            begin
                if (is_number_ch(c))
                begin
                    kind    = KIND_NUMBER;
                    handled = 1'b1;
                end
            end
            KIND_STRING:
            begin
                kind    = KIND_STRING;
                handled = 1'b1;
                // close on the matching quote or a newline
                if (c == (quote_dbl_reg ? CH_DQUOTE : CH_SQUOTE) || c == CH_NL)
                begin
                    mode_next       = MODE_NONE;
                    str_closed_next = 1'b1;
                end
            end
            default: ;
        endcase

        if (!handled)
        begin
            start           = 1'b1;
            str_closed_next = 1'b0;
            in_comment_next = 1'b0;
            if (is_alpha_ch(c) || c == CH_USCORE)
                kind = KIND_WORD;
            else if (is_space_ch(c))
                kind = KIND_SKIP;
            else if (opens_comment(c, col1, fixed_form_reg))
            begin
                kind            = KIND_SKIP;
                in_comment_next = 1'b1;
            end
            else if (is_digit_ch(c))
                kind = KIND_NUMBER;
            else if (c == CH_DQUOTE || c == CH_SQUOTE)
            begin
                kind           = KIND_STRING;
                quote_dbl_next = (c == CH_DQUOTE);
            end
            else
                kind = KIND_OTHER;
            mode_next = (kind == KIND_OTHER) ? MODE_NONE : kind;
        end

        col_one_next = (c == CH_NL);

        // restart the state after the last character of a text
        if (s1_data_reg.last_in_text)
        begin
            mode_next       = MODE_NONE;
            in_comment_next = 1'b0;
            quote_dbl_next  = 1'b0;
            str_closed_next = 1'b0;
            col_one_next    = 1'b1;
        end

        result.char_out    = c;
        result.chunk_kind  = kind;
        result.chunk_start = start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_form_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= MODE_NONE;
            in_comment_reg <= 1'b0;
            quote_dbl_reg  <= 1'b0;
            str_closed_reg <= 1'b0;
            col_one_reg    <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
                fixed_form_reg <= cfg_wr_data;

            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                mode_reg       <= mode_next;
                in_comment_reg <= in_comment_next;
                quote_dbl_reg  <= quote_dbl_next;
                str_closed_reg <= str_closed_next;
                col_one_reg    <= col_one_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

endmodule

`default_nettype wire
